FILE: rtl/pts_pkg.sv
// Package: shared types and constants of the periodic timer scheduler.
package pts_pkg;

   localparam int DEPTH      = 16;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MAX_FIRE   = 16;
   localparam int FCNT_W     = $clog2(MAX_FIRE + 1);
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = 1;
   localparam int QCNT_W     = 2;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_POST   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_POSTED = 3'd0,
      KIND_FIRED  = 3'd1,
      KIND_FULL   = 3'd2,
      KIND_DONE   = 3'd3,
      KIND_IDLE   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FIRE,
      ST_REMOVE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] period;
      logic        repeat_req;
      logic [31:0] target_id;
   } cmd_type;

endpackage

FILE: rtl/pts_req_if.sv
// Interface: command channel of the timer scheduler.
interface pts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] period;
   logic        repeat_req;
   logic [31:0] target_id;

   modport source (output valid, mode, period, repeat_req, target_id, input ready);
   modport sink   (input valid, mode, period, repeat_req, target_id, output ready);
endinterface

FILE: rtl/pts_rsp_if.sv
// Interface: result channel of the timer scheduler.
interface pts_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] timer_id;
   logic        last;

   modport source (output valid, kind, timer_id, last, input ready);
   modport sink   (input valid, kind, timer_id, last, output ready);
endinterface

FILE: rtl/pts_front.sv
// Front end: accepts commands, decodes the mode and queues them for the engine.
module pts_front (
   input  logic             clock,
   input  logic             reset,
   pts_req_if.sink          req,
   output logic             q_valid,
   output pts_pkg::cmd_type q_cmd,
   input  logic             q_pop
);
   import pts_pkg::*;

   cmd_type             queue_ff [QDEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   cmd_type             push_cmd;

   assign req.ready = (count_ff != QCNT_W'(QDEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = queue_ff[head_ff];

   always_comb begin
      push_cmd.op         = op_type'(req.mode);
      push_cmd.period     = req.period;
      push_cmd.repeat_req = req.repeat_req;
      push_cmd.target_id  = req.target_id;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = tail_ff + 1'b1;
      end
      if (q_pop && q_valid) begin
         head_in = head_ff + 1'b1;
      end
      case ({push, q_pop && q_valid})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/pts_engine.sv
// Back end: timer table, deadline scan, firing, removal and result register.
module pts_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  pts_pkg::cmd_type q_cmd,
   output logic             q_pop,
   pts_rsp_if.source        rsp
);
   import pts_pkg::*;

   state_type          state_ff, state_in;
   logic [63:0]        time_ff, time_in;
   logic [31:0]        next_id_ff, next_id_in;
   logic [DEPTH-1:0]   valid_ff, valid_in;
   logic [DEPTH-1:0]   fired_ff, fired_in;
   logic [31:0]        ent_id_ff     [DEPTH];
   logic [31:0]        ent_period_ff [DEPTH];
   logic [63:0]        ent_dl_ff     [DEPTH];
   logic               ent_rep_ff    [DEPTH];
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic [63:0]        best_dl_ff, best_dl_in;
   logic [31:0]        best_id_ff, best_id_in;
   logic [31:0]        best_period_ff, best_period_in;
   logic               best_rep_ff, best_rep_in;
   logic [FCNT_W-1:0]  nfire_ff, nfire_in;
   logic [31:0]        target_ff, target_in;
   kind_type           pend_kind_ff, pend_kind_in;
   logic [31:0]        pend_id_ff, pend_id_in;
   logic               pend_last_ff, pend_last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [31:0]        rsp_id_ff, rsp_id_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               wr_all, wr_dl;
   logic [IDX_W-1:0]   wr_idx;
   logic [63:0]        wr_dl_val;
   logic [63:0]        cur_dl;
   logic [31:0]        cur_id;
   logic               cand, better, out_free;
   logic               free_found;
   logic [IDX_W-1:0]   free_idx;
   logic [31:0]        id_inc;
   logic [FCNT_W-1:0]  nfire_inc;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.kind     = rsp_kind_ff;
   assign rsp.timer_id = rsp_id_ff;
   assign rsp.last     = rsp_last_ff;

   assign cur_dl    = ent_dl_ff[idx_ff];
   assign cur_id    = ent_id_ff[idx_ff];
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign id_inc    = next_id_ff + 32'd1;
   assign nfire_inc = nfire_ff + 1'b1;
   assign cand      = valid_ff[idx_ff] && !fired_ff[idx_ff] && (cur_dl < time_ff);
   assign better    = !found_ff || (cur_dl < best_dl_ff) ||
                      ((cur_dl == best_dl_ff) && (cur_id < best_id_ff));

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      time_in        = time_ff;
      next_id_in     = next_id_ff;
      valid_in       = valid_ff;
      fired_in       = fired_ff;
      idx_in         = idx_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_dl_in     = best_dl_ff;
      best_id_in     = best_id_ff;
      best_period_in = best_period_ff;
      best_rep_in    = best_rep_ff;
      nfire_in       = nfire_ff;
      target_in      = target_ff;
      pend_kind_in   = pend_kind_ff;
      pend_id_in     = pend_id_ff;
      pend_last_in   = pend_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_last_in    = rsp_last_ff;
      q_pop          = 1'b0;
      wr_all         = 1'b0;
      wr_dl          = 1'b0;
      wr_idx         = free_idx;
      wr_dl_val      = time_ff + {32'd0, q_cmd.period};

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               pend_last_in = 1'b1;
               case (q_cmd.op)
                  OP_TICK: begin
                     time_in  = time_ff + 64'd1;
                     fired_in = '0;
                     nfire_in = '0;
                     idx_in   = '0;
                     found_in = 1'b0;
                     state_in = ST_SCAN;
                  end
                  OP_POST: begin
                     if (free_found) begin
                        wr_all             = 1'b1;
                        valid_in[free_idx] = 1'b1;
                        pend_kind_in       = KIND_POSTED;
                        pend_id_in         = next_id_ff;
                        next_id_in         = (id_inc == 32'd0) ? 32'd1 : id_inc;
                     end else begin
                        pend_kind_in = KIND_FULL;
                        pend_id_in   = 32'd0;
                     end
                     state_in = ST_EMIT;
                  end
                  OP_REMOVE: begin
                     target_in    = q_cmd.target_id;
                     pend_kind_in = KIND_DONE;
                     pend_id_in   = q_cmd.target_id;
                     idx_in       = '0;
                     state_in     = ST_REMOVE;
                  end
                  OP_CLEAR: begin
                     valid_in     = '0;
                     pend_kind_in = KIND_DONE;
                     pend_id_in   = 32'd0;
                     state_in     = ST_EMIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (cand && better) begin
               found_in       = 1'b1;
               best_in        = idx_ff;
               best_dl_in     = cur_dl;
               best_id_in     = cur_id;
               best_period_in = ent_period_ff[idx_ff];
               best_rep_in    = ent_rep_ff[idx_ff];
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            if (found_ff) begin
               if (nfire_ff != '0) begin
                  pend_last_in = 1'b0;
                  state_in     = ST_EMIT;
               end else begin
                  state_in = ST_FIRE;
               end
            end else begin
               pend_last_in = 1'b1;
               if (nfire_ff == '0) begin
                  pend_kind_in = KIND_IDLE;
                  pend_id_in   = 32'd0;
               end
               state_in = ST_EMIT;
            end
         end
         ST_FIRE: begin
            fired_in[best_ff] = 1'b1;
            wr_idx            = best_ff;
            wr_dl_val         = time_ff + {32'd0, best_period_ff};
            if (best_rep_ff) begin
               wr_dl = 1'b1;
            end else begin
               valid_in[best_ff] = 1'b0;
            end
            pend_kind_in = KIND_FIRED;
            pend_id_in   = best_id_ff;
            nfire_in     = nfire_inc;
            if (nfire_inc == FCNT_W'(MAX_FIRE)) begin
               pend_last_in = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_REMOVE: begin
            if (valid_ff[idx_ff] && (cur_id == target_ff)) begin
               valid_in[idx_ff] = 1'b0;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_id_in    = pend_id_ff;
               rsp_last_in  = pend_last_ff;
               state_in     = pend_last_ff ? ST_IDLE : ST_FIRE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         next_id_ff   <= 32'd1;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         next_id_ff   <= next_id_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fired_ff       <= fired_in;
      idx_ff         <= idx_in;
      found_ff       <= found_in;
      best_ff        <= best_in;
      best_dl_ff     <= best_dl_in;
      best_id_ff     <= best_id_in;
      best_period_ff <= best_period_in;
      best_rep_ff    <= best_rep_in;
      nfire_ff       <= nfire_in;
      target_ff      <= target_in;
      pend_kind_ff   <= pend_kind_in;
      pend_id_ff     <= pend_id_in;
      pend_last_ff   <= pend_last_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_all) begin
         ent_id_ff[wr_idx]     <= next_id_ff;
         ent_period_ff[wr_idx] <= q_cmd.period;
         ent_rep_ff[wr_idx]    <= q_cmd.repeat_req;
         ent_dl_ff[wr_idx]     <= wr_dl_val;
      end else if (wr_dl) begin
         ent_dl_ff[wr_idx]     <= wr_dl_val;
      end
   end

endmodule

FILE: rtl/periodic_timer_scheduler.sv
// Top level: periodic timer scheduler with queued command front end.
// Commands enter a two-deep queue and are executed one at a time by the engine.
// A remove walks every slot of the table. A tick scans the table once per fired
// timer plus once more (not after the cap is reached), with at most 16 timers
// fired a tick; the table has a single port and is scanned one slot at a time.
module periodic_timer_scheduler (
   input  logic     clock,
   input  logic     reset,
   pts_req_if.sink  req,
   pts_rsp_if.source rsp
);
   import pts_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   pts_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop)
   );

   pts_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

FILE: rtl/pts_checker.sv
// Checker: port-level assertions for the timer scheduler, bound to the top level.
module pts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [31:0] rsp_timer_id,
   input logic        rsp_last
);
   import pts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_timer_id))
      else $error("stalled result changed");

   a_not_last_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == KIND_FIRED)
      else $error("non-final result is not a fired timer");

   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_IDLE |-> rsp_timer_id == 32'd0 && rsp_last)
      else $error("empty tick result malformed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind periodic_timer_scheduler pts_checker u_pts_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_kind     (rsp.kind),
   .rsp_timer_id (rsp.timer_id),
   .rsp_last     (rsp.last)
);
